// ===== rtl/rbod_pkg.sv =====
// Shared constants, types and helper functions for the rolling band outlier detector.
`timescale 1ns / 1ps

package rbod_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW_DEF  = 50;

    localparam int BAND_W = 4;
    localparam int KSQ_W  = 2 * BAND_W;
    localparam logic [BAND_W-1:0] BAND_RESET = 4'd5;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_BAND_ADDR = 3'd0;

    localparam int INDEX_W  = 32;
    localparam int OUT_BITS = 2 + INDEX_W + SAMPLE_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_TDATA_W - OUT_BITS;
    localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int MUL_DIGIT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_MUL_S2,
        ST_MUL_LHS,
        ST_MUL_RHS,
        ST_FIN
    } rbod_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rbod_mul_status_t;

    function automatic logic [KSQ_W-1:0] band_square(input logic [BAND_W-1:0] k);
        logic [KSQ_W-1:0] r;
        case (k)
            4'd0:  r = 8'd0;
            4'd1:  r = 8'd1;
            4'd2:  r = 8'd4;
            4'd3:  r = 8'd9;
            4'd4:  r = 8'd16;
            4'd5:  r = 8'd25;
            4'd6:  r = 8'd36;
            4'd7:  r = 8'd49;
            4'd8:  r = 8'd64;
            4'd9:  r = 8'd81;
            4'd10: r = 8'd100;
            4'd11: r = 8'd121;
            4'd12: r = 8'd144;
            4'd13: r = 8'd169;
            4'd14: r = 8'd196;
            default: r = 8'd225;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/rbod_mul.sv =====
// Iterative unsigned multiplier that consumes one digit of the second operand per cycle.
`timescale 1ns / 1ps

module rbod_mul
    import rbod_pkg::*;
#(
    parameter int A_W = 42,
    parameter int B_W = 22
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output rbod_mul_status_t     status,
    output logic [A_W+B_W-1:0]   product
);

    localparam int NSTEP = (B_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BP_W  = NSTEP * MUL_DIGIT;
    localparam int ACC_W = A_W + BP_W;
    localparam int PART_W = A_W + MUL_DIGIT;
    localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    logic [A_W-1:0]       a_reg;
    logic [BP_W-1:0]      b_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_DIGIT-1:0] digit;
    logic [PART_W-1:0]    part;

    assign digit    = b_reg[BP_W-1 -: MUL_DIGIT];
    assign part     = PART_W'(a_reg) * PART_W'(digit);
    assign acc_next = (acc_reg << MUL_DIGIT) + ACC_W'(part);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NSTEP - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= BP_W'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << MUL_DIGIT;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg[A_W+B_W-1:0];

endmodule

// ===== rtl/rolling_band_outlier_detector_core.sv =====
// Top level of the rolling band outlier detector with ring memory and exact band test.
// A warm-up sample goes from acceptance through PREP and FIN to its result register.
// With a full window it also passes SCALE, MUL_S2, MUL_LHS and MUL_RHS, where each product takes
// N = ceil(B/16) digit steps of the shared multiplier (B its narrow operand width); N = 2 by default.
// Samples are accepted only in IDLE, one at a time; FIN waits while the output is stalled.
// Reset clears the pointer, sums, count and result valid; K returns to 5; no memory clearing.
`timescale 1ns / 1ps

module rolling_band_outlier_detector_core
    import rbod_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] is_outlier, [1] window_full,
                                                   // [33:2] sample_index, [49:34] sample_echo
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int SB     = SAMPLE_BITS;
    localparam int WB     = $clog2(WINDOW + 1);
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int SUM_W  = SB + WB;
    localparam int D_W    = SB + WB + 1;
    localparam int AD_W   = SB + WB;
    localparam int AS_W   = SB + WB - 1;
    localparam int SQF_W  = 2 * SB;
    localparam int XSQ_W  = 2 * SB - 1;
    localparam int SQ_W   = 2 * SB - 2 + WB;
    localparam int SP_W   = SQ_W + WB;
    localparam int A1_W   = AD_W + WB;
    localparam int KK_W   = KSQ_W + WB;
    localparam int MA_T   = (A1_W > SP_W) ? A1_W : SP_W;
    localparam int MA     = (MA_T > AS_W) ? MA_T : AS_W;
    localparam int MB_T   = (AD_W > KK_W) ? AD_W : KK_W;
    localparam int MB     = (MB_T > AS_W) ? MB_T : AS_W;
    localparam int P_W    = MA + MB;

    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [INDEX_W-1:0] CNT_FULL = INDEX_W'(WINDOW);
    localparam logic [SP_W-1:0]    W_SP     = SP_W'(WINDOW);
    localparam logic [KK_W-1:0]    W_KK     = KK_W'(WINDOW);
    localparam logic [A1_W-1:0]    WM1_A1   = A1_W'(WINDOW - 1);

    rbod_state_t state_reg, state_next;

    logic [BAND_W-1:0]          band_reg, band_next;
    logic [PTR_W-1:0]           wp_reg, wp_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQ_W-1:0]            sq_reg, sq_next;
    logic [INDEX_W-1:0]         count_reg, count_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [SB-1:0]       mem [WINDOW];
    logic signed [SB-1:0]       rd_reg;

    logic signed [SB-1:0]       x_reg;
    logic [XSQ_W-1:0]           xsq_reg;
    logic                       full_reg;
    logic signed [SB-1:0]       old_reg;
    logic [XSQ_W-1:0]           oldsq_reg;
    logic [AD_W-1:0]            ad_reg;
    logic [AS_W-1:0]            as_reg;
    logic [SP_W-1:0]            wq_reg;
    logic [KK_W-1:0]            kk_reg;
    logic [A1_W-1:0]            a1_reg;
    logic [SP_W-1:0]            spread_reg;
    logic [P_W-1:0]             lhs_reg;
    logic                       outlier_reg;

    logic                       out_outlier_reg;
    logic                       out_full_reg;
    logic [INDEX_W-1:0]         out_index_reg;
    logic signed [SB-1:0]       out_echo_reg;

    logic                       accept;
    logic                       cfg_write;
    logic                       out_free;
    logic                       commit;
    logic                       mul_start;
    logic [MA-1:0]              mul_a;
    logic [MB-1:0]              mul_b;
    rbod_mul_status_t           mul_status;
    logic [P_W-1:0]             mul_product;

    logic signed [SB-1:0]       x_in;
    logic signed [SQF_W-1:0]    xsq_full;
    logic signed [SB-1:0]       old_val;
    logic signed [SQF_W-1:0]    oldsq_full;
    logic signed [D_W-1:0]      wx;
    logic signed [D_W-1:0]      diff;
    logic signed [D_W-1:0]      diff_abs;
    logic signed [SUM_W-1:0]    sum_abs;
    logic [P_W-1:0]             wq_ext;
    logic [P_W-1:0]             spread_full;

    rbod_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .status  (mul_status),
        .product (mul_product)
    );

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == REG_BAND_ADDR) ? APB_DATA_W'(band_reg) : '0;

    assign x_in       = s_axis_tdata[SB-1:0];
    assign xsq_full   = SQF_W'(x_in) * SQF_W'(x_in);
    assign old_val    = full_reg ? rd_reg : '0;
    assign oldsq_full = SQF_W'(old_val) * SQF_W'(old_val);
    assign wx         = D_W'(x_reg) * D_W'(WINDOW);
    assign diff       = wx - D_W'(sum_reg);
    assign diff_abs   = diff[D_W-1] ? -diff : diff;
    assign sum_abs    = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign wq_ext     = P_W'(wq_reg);
    assign spread_full = (wq_ext >= mul_product) ? (wq_ext - mul_product) : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_PREP;
            ST_PREP:    state_next = full_reg ? ST_SCALE : ST_FIN;
            ST_SCALE:   state_next = ST_MUL_S2;
            ST_MUL_S2:  if (mul_status.done) state_next = ST_MUL_LHS;
            ST_MUL_LHS: if (mul_status.done) state_next = ST_MUL_RHS;
            ST_MUL_RHS: if (mul_status.done) state_next = ST_FIN;
            ST_FIN:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        commit        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_SCALE:
            begin
                mul_start = 1'b1;
                mul_a     = MA'(as_reg);
                mul_b     = MB'(as_reg);
            end
            ST_MUL_S2:
            begin
                mul_start = mul_status.done;
                mul_a     = MA'(a1_reg);
                mul_b     = MB'(ad_reg);
            end
            ST_MUL_LHS:
            begin
                mul_start = mul_status.done;
                mul_a     = MA'(spread_reg);
                mul_b     = MB'(kk_reg);
            end
            ST_FIN:
            begin
                commit = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        band_next      = cfg_write && (paddr == REG_BAND_ADDR) ? pwdata[BAND_W-1:0] : band_reg;
        wp_next        = wp_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (commit)
        begin
            wp_next        = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
            sum_next       = sum_reg - SUM_W'(old_reg) + SUM_W'(x_reg);
            sq_next        = sq_reg - SQ_W'(oldsq_reg) + SQ_W'(xsq_reg);
            count_next     = (count_reg == '1) ? count_reg : count_reg + INDEX_W'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= BAND_RESET;
            wp_reg        <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            wp_reg        <= wp_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= mem[wp_reg];
        end
        if (commit)
        begin
            mem[wp_reg] <= x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= x_in;
            xsq_reg  <= xsq_full[XSQ_W-1:0];
            full_reg <= (count_reg >= CNT_FULL);
        end
        if (state_reg == ST_PREP)
        begin
            old_reg     <= old_val;
            oldsq_reg   <= oldsq_full[XSQ_W-1:0];
            ad_reg      <= diff_abs[AD_W-1:0];
            as_reg      <= sum_abs[AS_W-1:0];
            wq_reg      <= SP_W'(sq_reg) * W_SP;
            kk_reg      <= KK_W'(band_square(band_reg)) * W_KK;
            outlier_reg <= 1'b0;
        end
        if (state_reg == ST_SCALE)
        begin
            a1_reg <= A1_W'(ad_reg) * WM1_A1;
        end
        if ((state_reg == ST_MUL_S2) && mul_status.done)
        begin
            spread_reg <= spread_full[SP_W-1:0];
        end
        if ((state_reg == ST_MUL_LHS) && mul_status.done)
        begin
            lhs_reg <= mul_product;
        end
        if ((state_reg == ST_MUL_RHS) && mul_status.done)
        begin
            outlier_reg <= (lhs_reg > mul_product);
        end
        if (commit)
        begin
            out_outlier_reg <= outlier_reg;
            out_full_reg    <= full_reg;
            out_index_reg   <= count_next;
            out_echo_reg    <= x_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_echo_reg, out_index_reg, out_full_reg,
                            out_outlier_reg};

`ifndef SYNTHESIS
    a_mul_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_status.busy)
        else $error("Multiplier started while busy.");

    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_PREP))
        else $error("Accepted transaction did not enter preparation.");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("Result appeared without a commit.");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} < (PTR_W + 1)'(WINDOW))
        else $error("Write pointer left the ring.");

    a_count_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(commit))
        else $error("Sample count changed outside a commit.");
`endif

endmodule
